// ----- design/lmac_pkg.sv -----
// lmac_pkg: item types, command codes and queue entry format for the linear layer MAC.
// Used by lmac_front, lmac_back, linear_layer_mac_top and lmac_check. No dependencies.
package lmac_pkg;

    // Command codes carried by an input item
    localparam logic [1:0] CMD_WEIGHT  = 2'd0;
    localparam logic [1:0] CMD_BIAS    = 2'd1;
    localparam logic [1:0] CMD_FEATURE = 2'd2;

    // Input item as seen on the push side
    typedef struct packed {
        logic [1:0]         command;
        logic [3:0]         row;
        logic [2:0]         group;
        logic signed [31:0] value0;
        logic signed [31:0] value1;
        logic signed [31:0] value2;
        logic signed [31:0] value3;
    } in_item_t;

    // Result item as seen on the pop side
    typedef struct packed {
        logic signed [31:0] prediction;
        logic [3:0]         output_index;
        logic               sample_end;
        logic               batch_done;
    } out_item_t;

    // Operation after classification by the front end
    typedef enum logic [1:0] {
        OP_WEIGHT,
        OP_BIAS,
        OP_FEATURE
    } op_t;

    // Entry of the queue between front and back end
    typedef struct packed {
        op_t                op;
        logic [3:0]         row;
        logic [2:0]         group;
        logic signed [31:0] value0;
        logic signed [31:0] value1;
        logic signed [31:0] value2;
        logic signed [31:0] value3;
    } q_entry_t;

endpackage

// ----- design/lmac_ram.sv -----
// lmac_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
module lmac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem_reg[raddr];
    end

endmodule

// ----- design/lmac_fifo.sv -----
// lmac_fifo: small synchronous FIFO built from registers, head shown combinationally.
// No dependencies.
module lmac_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = data_reg[rd_ptr_reg];

    // Pointer and count update, pointers wrap at DEPTH
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- design/lmac_front.sv -----
// lmac_front: accepts input items, classifies them and drops the ones without effect.
// Depends on lmac_pkg and lmac_fifo.
module lmac_front
    import lmac_pkg::*;
#(
    parameter int ROW_COUNT = 10,
    parameter int NGROUPS   = 8,
    parameter int Q_DEPTH   = 4
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t item,
    output logic     full,
    input  logic     q_pop,
    output q_entry_t q_entry,
    output logic     q_empty
);

    q_entry_t entry;
    logic     keep;
    logic [$bits(q_entry_t)-1:0] q_rd_data;

    // Classify: unknown command and out-of-range loads change nothing
    always_comb
    begin
        entry.row    = item.row;
        entry.group  = item.group;
        entry.value0 = item.value0;
        entry.value1 = item.value1;
        entry.value2 = item.value2;
        entry.value3 = item.value3;
        entry.op     = OP_FEATURE;
        keep         = 1'b0;
        case (item.command)
            CMD_WEIGHT:
            begin
                entry.op = OP_WEIGHT;
                keep     = (int'(item.row) < ROW_COUNT) && (int'(item.group) < NGROUPS);
            end
            CMD_BIAS:
            begin
                entry.op = OP_BIAS;
                keep     = (int'(item.row) < ROW_COUNT);
            end
            CMD_FEATURE:
            begin
                entry.op = OP_FEATURE;
                keep     = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    lmac_fifo #(
        .WIDTH ($bits(q_entry_t)),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && keep),
        .wr_data (entry),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    assign q_entry = q_entry_t'(q_rd_data);

endmodule

// ----- design/lmac_back.sv -----
// lmac_back: executes classified items: weight/bias loads, the MAC pipeline and result emission.
// Depends on lmac_pkg and lmac_ram.
module lmac_back
    import lmac_pkg::*;
#(
    parameter int ROW_COUNT     = 10,
    parameter int FEATURE_COUNT = 32,
    parameter int DATA_WIDTH    = 32,
    parameter int FRAC_BITS     = 16,
    parameter int LANES         = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  q_entry_t    q_entry,
    input  logic        q_empty,
    output logic        q_pop,
    input  logic [15:0] batch_length,
    input  logic        res_full,
    output logic        res_push,
    output out_item_t   res_item
);

    localparam int DW      = DATA_WIDTH;
    localparam int NGROUPS = (FEATURE_COUNT + LANES - 1) / LANES;
    localparam int GW      = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
    localparam int OW      = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

    // Issue stage state
    logic            hold_reg;
    logic [GW-1:0]   grp_cnt_reg;
    logic [15:0]     smp_cnt_reg;
    logic            take;
    logic            is_feat;
    logic            last_grp;
    logic [16:0]     blen;
    logic            last_smp;
    logic [DW-1:0]   lane_in [LANES];
    logic [LANES*DW-1:0] wword;

    // Stage 1: weights being read
    logic            s1_valid_reg;
    logic            s1_last_reg;
    logic            s1_blast_reg;
    logic [GW-1:0]   s1_grp_reg;
    logic [DW-1:0]   s1_x_reg [LANES];
    logic [LANES*DW-1:0] rdata [ROW_COUNT];

    // Stage 2: products registered
    logic            s2_valid_reg;
    logic            s2_last_reg;
    logic            s2_blast_reg;
    logic [DW-1:0]   prod_reg  [ROW_COUNT][LANES];
    logic [DW-1:0]   prod_next [ROW_COUNT][LANES];

    // Accumulators, bias and emission
    logic [DW-1:0]   acc_reg  [ROW_COUNT];
    logic [DW-1:0]   acc_sum  [ROW_COUNT];
    logic [DW-1:0]   bias_reg [ROW_COUNT];
    logic            emit_reg;
    logic            blast_reg;
    logic [OW-1:0]   emit_cnt_reg;
    logic            emit_last;
    logic signed [DW-1:0] pred;

    // Lane values from the four value fields, later lanes read as zero
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            case (k)
                0:       lane_in[k] = q_entry.value0[DW-1:0];
                1:       lane_in[k] = q_entry.value1[DW-1:0];
                2:       lane_in[k] = q_entry.value2[DW-1:0];
                3:       lane_in[k] = q_entry.value3[DW-1:0];
                default: lane_in[k] = '0;
            endcase
            wword[k*DW +: DW] = lane_in[k];
        end
    end

    // Issue control; a sample end holds issue until its results are out
    assign take     = !q_empty && !hold_reg;
    assign q_pop    = take;
    assign is_feat  = take && (q_entry.op == OP_FEATURE);
    assign last_grp = (grp_cnt_reg == GW'(NGROUPS - 1));
    assign blen     = (batch_length == '0) ? 17'h10000 : {1'b0, batch_length};
    assign last_smp = ({1'b0, smp_cnt_reg} + 17'd1) >= blen;

    // Weight memory: one word of all lanes per row and group
    for (genvar j = 0; j < ROW_COUNT; j++)
    begin : g_row
        lmac_ram #(
            .WIDTH (LANES * DW),
            .DEPTH (NGROUPS)
        ) u_wmem (
            .clk   (clk),
            .we    (take && (q_entry.op == OP_WEIGHT) && (int'(q_entry.row) == j)),
            .waddr (GW'(q_entry.group)),
            .wdata (wword),
            .raddr (grp_cnt_reg),
            .rdata (rdata[j])
        );

        // Truncating Q-format products, lanes past the last feature give zero
        for (genvar k = 0; k < LANES; k++)
        begin : g_lane
            logic signed [2*DW-1:0] p;
            logic signed [63:0]     pe;
            logic signed [63:0]     ps;
            always_comb
            begin
                p  = $signed(s1_x_reg[k]) * $signed(rdata[j][k*DW +: DW]);
                pe = 64'(p);
                ps = pe >>> FRAC_BITS;
                if (int'(s1_grp_reg) * LANES + k < FEATURE_COUNT)
                begin
                    prod_next[j][k] = ps[DW-1:0];
                end
                else
                begin
                    prod_next[j][k] = '0;
                end
            end
        end

        // Lane sum into the accumulator, wrapping
        always_comb
        begin
            acc_sum[j] = acc_reg[j];
            for (int k = 0; k < LANES; k++)
            begin
                acc_sum[j] = acc_sum[j] + prod_reg[j][k];
            end
        end
    end

    assign emit_last = (emit_cnt_reg == OW'(ROW_COUNT - 1));
    assign res_push  = emit_reg && !res_full;
    assign pred      = $signed(acc_reg[emit_cnt_reg] + bias_reg[emit_cnt_reg]);

    // Result item
    always_comb
    begin
        res_item.prediction   = 32'(pred);
        res_item.output_index = 4'(emit_cnt_reg);
        res_item.sample_end   = emit_last;
        res_item.batch_done   = emit_last && blast_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg     <= 1'b0;
            grp_cnt_reg  <= '0;
            smp_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s1_blast_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            s2_blast_reg <= 1'b0;
            emit_reg     <= 1'b0;
            blast_reg    <= 1'b0;
            emit_cnt_reg <= '0;
            for (int j = 0; j < ROW_COUNT; j++)
            begin
                acc_reg[j] <= '0;
            end
        end
        else
        begin
            // issue
            s1_valid_reg <= is_feat;
            s1_last_reg  <= is_feat && last_grp;
            s1_blast_reg <= last_smp;
            if (is_feat)
            begin
                if (last_grp)
                begin
                    grp_cnt_reg <= '0;
                    hold_reg    <= 1'b1;
                    smp_cnt_reg <= last_smp ? '0 : smp_cnt_reg + 1'b1;
                end
                else
                begin
                    grp_cnt_reg <= grp_cnt_reg + 1'b1;
                end
            end
            // multiply
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_last_reg;
            s2_blast_reg <= s1_blast_reg;
            // accumulate
            if (s2_valid_reg)
            begin
                for (int j = 0; j < ROW_COUNT; j++)
                begin
                    acc_reg[j] <= acc_sum[j];
                end
                if (s2_last_reg)
                begin
                    emit_reg     <= 1'b1;
                    blast_reg    <= s2_blast_reg;
                    emit_cnt_reg <= '0;
                end
            end
            // emit one result per cycle while the result queue has room, then clear
            if (res_push)
            begin
                if (emit_last)
                begin
                    emit_reg     <= 1'b0;
                    hold_reg     <= 1'b0;
                    emit_cnt_reg <= '0;
                    for (int j = 0; j < ROW_COUNT; j++)
                    begin
                        acc_reg[j] <= '0;
                    end
                end
                else
                begin
                    emit_cnt_reg <= emit_cnt_reg + 1'b1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (is_feat)
        begin
            s1_grp_reg <= grp_cnt_reg;
            for (int k = 0; k < LANES; k++)
            begin
                s1_x_reg[k] <= lane_in[k];
            end
        end
        for (int j = 0; j < ROW_COUNT; j++)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                prod_reg[j][k] <= prod_next[j][k];
            end
        end
        if (take && (q_entry.op == OP_BIAS))
        begin
            bias_reg[OW'(q_entry.row)] <= q_entry.value0[DW-1:0];
        end
    end

endmodule

// ----- design/linear_layer_mac_top.sv -----
// linear_layer_mac_top: top level of the fixed-point linear layer y = A*x + b.
// Depends on lmac_pkg, lmac_front, lmac_back and lmac_fifo.
//
// Items go in through a 4-deep queue at one per cycle while it is not full. Load and
// feature items then leave the queue one per cycle, unless issue is held, into a
// three-stage back end (weight read, registered multiply of every row and lane,
// accumulate). After the last feature group of a sample the back end stops taking
// items while the pipeline drains and its ROW_COUNT results go, one per cycle while
// the 4-deep result queue is not full, into that queue; the pop rate sets its length.
module linear_layer_mac_top
    import lmac_pkg::*;
#(
    parameter int ROW_COUNT     = 10,
    parameter int FEATURE_COUNT = 32,
    parameter int DATA_WIDTH    = 32,
    parameter int FRAC_BITS     = 16,
    parameter int LANES         = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  in_item_t    item,
    output logic        full,
    input  logic        pop,
    output out_item_t   result,
    output logic        empty,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data
);

    localparam int NGROUPS = (FEATURE_COUNT + LANES - 1) / LANES;

    q_entry_t    q_entry;
    logic        q_empty;
    logic        q_pop;
    logic [15:0] batch_length_reg;
    logic        res_full;
    logic        res_push;
    out_item_t   res_item;
    logic [$bits(out_item_t)-1:0] res_rd_data;

    // Batch length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_length_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            batch_length_reg <= cfg_data;
        end
    end

    lmac_front #(
        .ROW_COUNT (ROW_COUNT),
        .NGROUPS   (NGROUPS),
        .Q_DEPTH   (4)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .full    (full),
        .q_pop   (q_pop),
        .q_entry (q_entry),
        .q_empty (q_empty)
    );

    lmac_back #(
        .ROW_COUNT     (ROW_COUNT),
        .FEATURE_COUNT (FEATURE_COUNT),
        .DATA_WIDTH    (DATA_WIDTH),
        .FRAC_BITS     (FRAC_BITS),
        .LANES         (LANES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_entry      (q_entry),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .batch_length (batch_length_reg),
        .res_full     (res_full),
        .res_push     (res_push),
        .res_item     (res_item)
    );

    // Result queue
    lmac_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (4)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_item),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd_data),
        .empty   (empty)
    );

    assign result = out_item_t'(res_rd_data);

endmodule

// ----- design/lmac_check.sv -----
// lmac_check: port-level assertions for linear_layer_mac_top, attached by bind.
// Depends on lmac_pkg.
module lmac_check
    import lmac_pkg::*;
#(
    parameter int ROW_COUNT = 10
) (
    input logic      clk,
    input logic      rst_n,
    input logic      pop,
    input logic      empty,
    input out_item_t result
);

    // A batch ends only on the last result of a sample
    a_done_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.batch_done) |-> result.sample_end)
        else $error("batch_done without sample_end");

    // The last result of a sample belongs to the last row
    a_end_row: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.sample_end) |-> (result.output_index == 4'(ROW_COUNT - 1)))
        else $error("sample_end on wrong row");

    // Results after the first of a sample count up by row
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !result.sample_end) ##1 !empty
        |-> (result.output_index == $past(result.output_index) + 4'd1))
        else $error("result rows out of order");

    // A waiting result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed");

endmodule

bind linear_layer_mac_top lmac_check #(
    .ROW_COUNT (ROW_COUNT)
) u_lmac_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);
